>>> hw/rtl/rrc_pkg.sv
// Package for the reference-counted result cache.
// Holds mode and status codes, entry and result types, default parameters.
// No dependencies.
`default_nettype none

package rrc_pkg;

  localparam int NODE_COUNT_DEF  = 256;
  localparam int HANDLE_BITS_DEF = 32;

  localparam int MODE_W   = 3;
  localparam int NODE_W   = 8;
  localparam int VALUE_W  = 32;
  localparam int DESC_W   = 8;
  localparam int REUSE_W  = 16;
  localparam int STATUS_W = 2;

  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 64;

  localparam logic [MODE_W-1:0] MODE_SET   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUT   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_GET   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DEC   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd4;
  localparam logic [MODE_W-1:0] MODE_QUERY = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EXPIRED = 2'd2;

  localparam logic signed [REUSE_W-1:0] REUSE_MAX = 16'sh7FFF;
  localparam logic signed [REUSE_W-1:0] REUSE_MIN = 16'sh8000;

  // per-node static part: kept across clear all
  typedef struct packed {
    logic              present;
    logic [DESC_W-1:0] consumers;
  } node_info_t;

  // per-run part, besides the handle
  typedef struct packed {
    logic               has_data;
    logic [REUSE_W-1:0] reuse;
    logic               filled;
  } run_info_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  data_out;
    logic                data_held;
    logic [REUSE_W-1:0]  reuse_out;
    logic [DESC_W-1:0]   descendants_out;
    logic                cached_in_run;
  } result_t;

  localparam int NODE_INFO_W = $bits(node_info_t);
  localparam int RUN_INFO_W  = $bits(run_info_t);

endpackage

`default_nettype wire

>>> hw/rtl/rrc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rrc_update.sv
// Entry update and result formation for one operation.
// Depends on rrc_pkg.
`default_nettype none

module rrc_update
  import rrc_pkg::*;
#(
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  wire logic [MODE_W-1:0]      mode,
  input  wire logic [VALUE_W-1:0]     data_value,
  input  wire logic                   from_eval,
  input  wire logic [DESC_W-1:0]      descendants,
  input  wire logic [REUSE_W-1:0]     reuse_start,
  input  wire logic                   in_range,
  input  wire node_info_t             rd_node,
  input  wire logic [HANDLE_BITS-1:0] rd_handle,
  input  wire run_info_t              rd_run,
  output      logic                   wr_node_en,
  output      node_info_t             wr_node,
  output      logic                   wr_run_en,
  output      logic [HANDLE_BITS-1:0] wr_handle,
  output      run_info_t              wr_run,
  output      logic                   start_sweep,
  output      result_t                res
);

  logic                      found;
  logic                      found_out;
  logic [STATUS_W-1:0]       status;
  logic [HANDLE_BITS-1:0]    dout;
  logic [HANDLE_BITS-1:0]    value_h;
  logic signed [REUSE_W-1:0] r_cur;
  logic signed [REUSE_W+1:0] put_sum;
  logic signed [REUSE_W-1:0] put_sat;
  logic signed [REUSE_W-1:0] dec_sat;
  logic signed [REUSE_W-1:0] get_dec;

  assign found   = in_range && rd_node.present;
  assign value_h = HANDLE_BITS'(64'(data_value));
  assign r_cur   = $signed(rd_run.reuse);
  assign put_sum = $signed({{2{r_cur[REUSE_W-1]}}, r_cur})
                 + $signed({2'b00, 8'd0, rd_node.consumers})
                 - $signed({{(REUSE_W+1){1'b0}}, from_eval});
  assign put_sat = (put_sum > $signed(18'sd32767))  ? REUSE_MAX :
                   (put_sum < -$signed(18'sd32768)) ? REUSE_MIN :
                   REUSE_W'(put_sum);
  assign dec_sat = (r_cur == REUSE_MIN) ? REUSE_MIN : r_cur - 16'sd1;
  assign get_dec = r_cur - 16'sd1;

  always_comb begin
    wr_node_en  = 1'b0;
    wr_node     = rd_node;
    wr_run_en   = 1'b0;
    wr_handle   = rd_handle;
    wr_run      = rd_run;
    start_sweep = 1'b0;
    found_out   = found;
    status      = found ? ST_OK : ST_MISS;
    dout        = '0;
    unique case (mode)
      MODE_SET: begin
        if (in_range) begin
          wr_node_en        = 1'b1;
          wr_node.present   = 1'b1;
          wr_node.consumers = descendants;
          wr_run_en         = 1'b1;
          if (!found) begin
            wr_handle       = '0;
            wr_run.has_data = 1'b0;
            wr_run.filled   = 1'b0;
          end
          wr_run.reuse = reuse_start;
          found_out    = 1'b1;
          status       = ST_OK;
        end
      end
      MODE_PUT: begin
        if (found && (!from_eval || rd_node.consumers > 8'd1)) begin
          wr_run_en       = 1'b1;
          wr_handle       = value_h;
          wr_run.has_data = 1'b1;
          wr_run.reuse    = put_sat;
          wr_run.filled   = 1'b1;
        end
      end
      MODE_GET: begin
        if (found) begin
          if (r_cur > 16'sd0) begin
            dout         = rd_run.has_data ? rd_handle : '0;
            wr_run_en    = 1'b1;
            wr_run.reuse = get_dec;
            if (get_dec == 16'sd0) begin
              wr_run.has_data = 1'b0;
              wr_handle       = '0;
            end
          end else begin
            status = rd_run.filled ? ST_EXPIRED : ST_MISS;
          end
        end
      end
      MODE_DEC: begin
        if (found) begin
          wr_run_en    = 1'b1;
          wr_run.reuse = dec_sat;
          if (dec_sat == 16'sd0) begin
            wr_run.has_data = 1'b0;
            wr_handle       = '0;
          end
        end
      end
      MODE_CLEAR: begin
        start_sweep = 1'b1;
        status      = ST_OK;
        wr_run      = '0;
        wr_handle   = '0;
      end
      MODE_QUERY: begin
        if (found) begin
          dout = rd_run.has_data ? rd_handle : '0;
        end
      end
      default: begin
        status = ST_MISS;
      end
    endcase
  end

  always_comb begin
    res.status   = status;
    res.data_out = VALUE_W'(64'(dout));
    if (found_out) begin
      res.data_held       = wr_run.has_data;
      res.reuse_out       = wr_run.reuse;
      res.descendants_out = wr_node.consumers;
      res.cached_in_run   = wr_run.filled;
    end else begin
      res.data_held       = 1'b0;
      res.reuse_out       = '0;
      res.descendants_out = '0;
      res.cached_in_run   = 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/refcounted_result_cache_top.sv
// Top level of the reference-counted result cache: control, sweeps, memories.
// Depends on rrc_pkg, rrc_ram and rrc_update.
//
//  channel  dir  transfer on          payload
//  s_*      in   s_tvalid & s_tready  op: mode, node_index, data_value, from_eval,
//                                     descendants, reuse_start
//  m_*      out  m_tvalid & m_tready  result: status, data_out, data_held,
//                                     reuse_out, descendants_out, cached_in_run
//
// Every operation runs as table read, then update, write-back and result.
// Clear all then sweeps the run-info memory, one row per cycle.
// After rst, a pass over every row clears the node-info memory; s_tready stays low.
// A result waiting in the output register holds the update stage until taken.
`default_nettype none

module refcounted_result_cache_top
  import rrc_pkg::*;
#(
  parameter int NODE_COUNT  = NODE_COUNT_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output      logic                 s_tready,
  // mode[2:0], node_index[10:3], data_value[42:11], from_eval[43],
  // descendants[51:44], reuse_start[67:52], zero[71:68]
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  output      logic                 m_tvalid,
  input  wire logic                 m_tready,
  // status[1:0], data_out[33:2], data_held[34], reuse_out[50:35],
  // descendants_out[58:51], cached_in_run[59], zero[63:60]
  output      logic [M_TDATA_W-1:0] m_tdata
);

  localparam int IDX_W   = $clog2(NODE_COUNT);
  localparam int RUN_W   = HANDLE_BITS + RUN_INFO_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_COUNT - 1);

  typedef enum logic [3:0] {
    S_INIT  = 4'b0001,
    S_IDLE  = 4'b0010,
    S_EXEC  = 4'b0100,
    S_SWEEP = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [IDX_W-1:0]   sweep_cnt;
  logic [MODE_W-1:0]  mode;
  logic [NODE_W-1:0]  node_index;
  logic [VALUE_W-1:0] data_value;
  logic               from_eval;
  logic [DESC_W-1:0]  descendants;
  logic [REUSE_W-1:0] reuse_start;
  logic               in_range;
  result_t            res_out;

  logic               s_xfer;
  logic               out_free;
  logic               commit;
  logic [NODE_W-1:0]  in_node;
  logic [IDX_W-1:0]   in_addr;
  logic [IDX_W-1:0]   op_addr;

  logic [NODE_INFO_W-1:0] node_rdata;
  logic [RUN_W-1:0]       run_rdata;
  logic                   node_we;
  logic [IDX_W-1:0]       node_waddr;
  logic [NODE_INFO_W-1:0] node_wdata;
  logic                   run_we;
  logic [IDX_W-1:0]       run_waddr;
  logic [RUN_W-1:0]       run_wdata;

  logic                   upd_node_en;
  node_info_t             upd_node;
  logic                   upd_run_en;
  logic [HANDLE_BITS-1:0] upd_handle;
  run_info_t              upd_run;
  logic                   upd_sweep;
  result_t                upd_res;

  assign s_tready = (state == S_IDLE);
  assign s_xfer   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign commit   = (state == S_EXEC) && out_free;
  assign in_node  = s_tdata[10:3];
  assign in_addr  = IDX_W'(in_node);
  assign op_addr  = IDX_W'(node_index);

  rrc_ram #(
    .WIDTH(NODE_INFO_W),
    .DEPTH(NODE_COUNT)
  ) u_node_ram (
    .clk  (clk),
    .we   (node_we),
    .waddr(node_waddr),
    .wdata(node_wdata),
    .re   (s_xfer),
    .raddr(in_addr),
    .rdata(node_rdata)
  );

  rrc_ram #(
    .WIDTH(RUN_W),
    .DEPTH(NODE_COUNT)
  ) u_run_ram (
    .clk  (clk),
    .we   (run_we),
    .waddr(run_waddr),
    .wdata(run_wdata),
    .re   (s_xfer),
    .raddr(in_addr),
    .rdata(run_rdata)
  );

  rrc_update #(
    .HANDLE_BITS(HANDLE_BITS)
  ) u_update (
    .mode       (mode),
    .data_value (data_value),
    .from_eval  (from_eval),
    .descendants(descendants),
    .reuse_start(reuse_start),
    .in_range   (in_range),
    .rd_node    (node_info_t'(node_rdata)),
    .rd_handle  (run_rdata[RUN_W-1:RUN_INFO_W]),
    .rd_run     (run_info_t'(run_rdata[RUN_INFO_W-1:0])),
    .wr_node_en (upd_node_en),
    .wr_node    (upd_node),
    .wr_run_en  (upd_run_en),
    .wr_handle  (upd_handle),
    .wr_run     (upd_run),
    .start_sweep(upd_sweep),
    .res        (upd_res)
  );

  always_comb begin
    if (state == S_INIT) begin
      node_we    = 1'b1;
      node_waddr = sweep_cnt;
      node_wdata = '0;
    end else begin
      node_we    = commit && upd_node_en;
      node_waddr = op_addr;
      node_wdata = NODE_INFO_W'(upd_node);
    end
    if (state == S_SWEEP) begin
      run_we    = 1'b1;
      run_waddr = sweep_cnt;
      run_wdata = '0;
    end else begin
      run_we    = commit && upd_run_en;
      run_waddr = op_addr;
      run_wdata = {upd_handle, RUN_INFO_W'(upd_run)};
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (sweep_cnt == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_xfer) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_next = upd_sweep ? S_SWEEP : S_IDLE;
        end
      end
      S_SWEEP: begin
        if (sweep_cnt == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      sweep_cnt <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_INIT || state == S_SWEEP) begin
        sweep_cnt <= (sweep_cnt == LAST_IDX) ? '0 : sweep_cnt + 1'b1;
      end
      if (commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      mode        <= s_tdata[2:0];
      node_index  <= in_node;
      data_value  <= s_tdata[42:11];
      from_eval   <= s_tdata[43];
      descendants <= s_tdata[51:44];
      reuse_start <= s_tdata[67:52];
      in_range    <= (32'(in_node) < 32'(NODE_COUNT));
    end
    if (commit) begin
      res_out <= upd_res;
    end
  end

  assign m_tdata = {4'b0000, res_out.cached_in_run, res_out.descendants_out,
                    res_out.reuse_out, res_out.data_held, res_out.data_out,
                    res_out.status};

endmodule

`default_nettype wire

>>> test/tb_refcounted_result_cache_top.sv
// Self-checking testbench for refcounted_result_cache_top: a directed table, then random
// operations under several idle and stall mixes, each result checked against its typed row or a predictor.
// Depends on rrc_pkg and the cache RTL.
`default_nettype none

module tb_refcounted_result_cache_top;
  import rrc_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;
  localparam int NODES        = NODE_COUNT_DEF;
  localparam int RAND_PER_MIX = 463;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [MODE_W-1:0]         mode;
    logic [NODE_W-1:0]         node;
    logic [VALUE_W-1:0]        handle;
    logic                      eval;
    logic [DESC_W-1:0]         desc;
    logic signed [REUSE_W-1:0] reuse_init;
  } cache_op_t;

  typedef struct {
    logic [STATUS_W-1:0]       status;
    logic [VALUE_W-1:0]        handle;
    logic                      held;
    logic signed [REUSE_W-1:0] reuse;
    logic [DESC_W-1:0]         desc;
    logic                      filled;
  } cache_res_t;

  typedef struct {
    cache_op_t  op;
    bit         typed;
    cache_res_t res;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  wire logic            s_tready;
  // mode, node_index, data_value, from_eval, descendants, reuse_start, zero pad
  logic [S_TDATA_W-1:0] s_tdata = '0;
  wire logic            m_tvalid;
  logic                 m_tready = 1'b0;
  // status, data_out, data_held, reuse_out, descendants_out, cached_in_run, zero pad
  wire logic [M_TDATA_W-1:0] m_tdata;

  refcounted_result_cache_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  bit                 node_live   [NODES];
  logic [VALUE_W-1:0] node_handle [NODES];
  bit                 node_held   [NODES];
  int                 node_desc   [NODES];
  int                 node_reuse  [NODES];
  bit                 node_filled [NODES];

  cache_res_t expected_q[$];
  stim_row_t  directed_rows[$];
  int mismatch_count = 0;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  function automatic int clamp_reuse(int v);
    if (v > int'(REUSE_MAX)) return int'(REUSE_MAX);
    if (v < int'(REUSE_MIN)) return int'(REUSE_MIN);
    return v;
  endfunction

  function automatic cache_res_t cache_apply(cache_op_t op);
    cache_res_t r;
    int idx;
    bit hit;
    idx = op.node;
    hit = (idx < NODES) && node_live[idx];
    r.status = hit ? ST_OK : ST_MISS;
    r.handle = '0;
    case (op.mode)
      MODE_SET: begin
        if (idx < NODES) begin
          if (!hit) begin
            node_live[idx] = 1'b1;
            node_handle[idx] = '0;
            node_held[idx] = 1'b0;
            node_filled[idx] = 1'b0;
          end
          node_reuse[idx] = op.reuse_init;
          node_desc[idx] = op.desc;
          hit = 1'b1;
          r.status = ST_OK;
        end
      end
      MODE_PUT: begin
        if (hit && (!op.eval || node_desc[idx] > 1)) begin
          node_handle[idx] = op.handle;
          node_held[idx] = 1'b1;
          node_reuse[idx] = clamp_reuse(node_reuse[idx] + node_desc[idx] - (op.eval ? 1 : 0));
          node_filled[idx] = 1'b1;
        end
      end
      MODE_GET: begin
        if (hit) begin
          if (node_reuse[idx] > 0) begin
            r.handle = node_held[idx] ? node_handle[idx] : '0;
            node_reuse[idx] -= 1;
            if (node_reuse[idx] == 0) begin
              node_held[idx] = 1'b0;
              node_handle[idx] = '0;
            end
          end else begin
            r.status = node_filled[idx] ? ST_EXPIRED : ST_MISS;
          end
        end
      end
      MODE_DEC: begin
        if (hit) begin
          node_reuse[idx] = clamp_reuse(node_reuse[idx] - 1);
          if (node_reuse[idx] == 0) begin
            node_held[idx] = 1'b0;
            node_handle[idx] = '0;
          end
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < NODES; i++) begin
          if (node_live[i]) begin
            node_reuse[i] = 0;
            node_held[i] = 1'b0;
            node_handle[i] = '0;
            node_filled[i] = 1'b0;
          end
        end
        r.status = ST_OK;
      end
      MODE_QUERY: begin
        if (hit) r.handle = node_held[idx] ? node_handle[idx] : '0;
      end
      default: r.status = ST_MISS;
    endcase
    r.held   = hit ? node_held[idx] : 1'b0;
    r.reuse  = hit ? REUSE_W'(node_reuse[idx]) : '0;
    r.desc   = hit ? DESC_W'(node_desc[idx]) : '0;
    r.filled = hit ? node_filled[idx] : 1'b0;
    return r;
  endfunction

  function automatic cache_op_t rand_op();
    cache_op_t op;
    int pick;
    pick = $urandom_range(999);
    if (pick < 150) op.mode = MODE_SET;
    else if (pick < 350) op.mode = MODE_PUT;
    else if (pick < 660) op.mode = MODE_GET;
    else if (pick < 790) op.mode = MODE_DEC;
    else if (pick < 960) op.mode = MODE_QUERY;
    else if (pick < 975) op.mode = MODE_CLEAR;
    else op.mode = $urandom_range(1) ? MODE_SPARE7 : MODE_SPARE6;
    // most traffic on a small node pool so sequences build up
    op.node = NODE_W'(($urandom_range(99) < 85) ? $urandom_range(15) : $urandom_range(255));
    op.handle = $urandom;
    op.eval = 1'($urandom_range(1));
    op.desc = DESC_W'(($urandom_range(99) < 75) ? $urandom_range(3) : $urandom_range(255));
    pick = $urandom_range(9);
    if (pick < 6) op.reuse_init = REUSE_W'(int'($urandom_range(6)) - 2);
    else if (pick < 8) op.reuse_init = REUSE_W'($urandom);
    else if (pick == 8) op.reuse_init = REUSE_MAX - REUSE_W'($urandom_range(3));
    else op.reuse_init = REUSE_MIN + REUSE_W'($urandom_range(3));
    return op;
  endfunction

  task automatic row_pred(logic [MODE_W-1:0] mode, int node, logic [VALUE_W-1:0] handle,
                          bit eval, int desc, int reuse_init);
    stim_row_t row;
    row.op = '{mode, NODE_W'(node), handle, eval, DESC_W'(desc), REUSE_W'(reuse_init)};
    row.typed = 1'b0;
    row.res = '{ST_OK, '0, 1'b0, '0, '0, 1'b0};
    directed_rows.push_back(row);
  endtask

  task automatic row_typed(logic [MODE_W-1:0] mode, int node, logic [VALUE_W-1:0] handle,
                           bit eval, int desc, int reuse_init, logic [STATUS_W-1:0] st,
                           logic [VALUE_W-1:0] dout, bit held, int ro, int dsc, bit fl);
    stim_row_t row;
    row.op = '{mode, NODE_W'(node), handle, eval, DESC_W'(desc), REUSE_W'(reuse_init)};
    row.typed = 1'b1;
    row.res = '{st, dout, held, REUSE_W'(ro), DESC_W'(dsc), fl};
    directed_rows.push_back(row);
  endtask

  task automatic offer_op(cache_op_t op, bit typed, cache_res_t typed_res);
    cache_res_t pred;
    while ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, op.reuse_init, op.desc, op.eval, op.handle, op.node, op.mode};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = cache_apply(op);
    expected_q.push_back(typed ? typed_res : pred);
  endtask

  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cache_res_t got;
    cache_res_t want;
    if (m_tvalid && m_tready) begin
      got = '{m_tdata[1:0], m_tdata[33:2], m_tdata[34], m_tdata[50:35],
              m_tdata[58:51], m_tdata[59]};
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer %0h", m_tdata);
        mismatch_count++;
      end else begin
        want = expected_q.pop_front();
        if (got.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, got.status);
          mismatch_count++;
        end
        if (got.handle !== want.handle) begin
          $error("data_out expected %0h got %0h", want.handle, got.handle);
          mismatch_count++;
        end
        if (got.held !== want.held) begin
          $error("data_held expected %0d got %0d", want.held, got.held);
          mismatch_count++;
        end
        if (got.reuse !== want.reuse) begin
          $error("reuse_out expected %0d got %0d", want.reuse, got.reuse);
          mismatch_count++;
        end
        if (got.desc !== want.desc) begin
          $error("descendants_out expected %0d got %0d", want.desc, got.desc);
          mismatch_count++;
        end
        if (got.filled !== want.filled) begin
          $error("cached_in_run expected %0d got %0d", want.filled, got.filled);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    cache_res_t unused;
    unused = '{ST_OK, '0, 1'b0, '0, '0, 1'b0};

    // empty table
    row_typed(MODE_QUERY, 0, 0, 0, 0, 0, ST_MISS, 0, 0, 0, 0, 0);
    row_typed(MODE_GET, 255, 0, 0, 0, 0, ST_MISS, 0, 0, 0, 0, 0);
    row_typed(MODE_PUT, 7, 32'hDEADBEEF, 0, 0, 0, ST_MISS, 0, 0, 0, 0, 0);
    row_typed(MODE_DEC, 7, 0, 0, 0, 0, ST_MISS, 0, 0, 0, 0, 0);
    row_typed(MODE_SPARE6, 0, 0, 0, 0, 0, ST_MISS, 0, 0, 0, 0, 0);
    row_typed(MODE_SPARE7, 255, 0, 0, 0, 0, ST_MISS, 0, 0, 0, 0, 0);
    // upper saturation
    row_typed(MODE_SET, 0, 0, 0, 255, REUSE_MAX, ST_OK, 0, 0, REUSE_MAX, 255, 0);
    row_typed(MODE_PUT, 0, 32'hFFFFFFFF, 0, 0, 0, ST_OK, 0, 1, REUSE_MAX, 255, 1);
    row_typed(MODE_GET, 0, 0, 0, 0, 0, ST_OK, 32'hFFFFFFFF, 1, REUSE_MAX - 1, 255, 1);
    // single consumer eval put, drop at zero, expired get
    row_typed(MODE_SET, 1, 0, 0, 1, 0, ST_OK, 0, 0, 0, 1, 0);
    row_typed(MODE_PUT, 1, 32'h12345678, 1, 0, 0, ST_OK, 0, 0, 0, 1, 0);
    row_typed(MODE_GET, 1, 0, 0, 0, 0, ST_MISS, 0, 0, 0, 1, 0);
    row_typed(MODE_PUT, 1, 32'h12345678, 0, 0, 0, ST_OK, 0, 1, 1, 1, 1);
    row_typed(MODE_GET, 1, 0, 0, 0, 0, ST_OK, 32'h12345678, 0, 0, 1, 1);
    row_typed(MODE_GET, 1, 0, 0, 0, 0, ST_EXPIRED, 0, 0, 0, 1, 1);
    // lower saturation
    row_typed(MODE_SET, 2, 0, 0, 0, REUSE_MIN, ST_OK, 0, 0, REUSE_MIN, 0, 0);
    row_typed(MODE_DEC, 2, 0, 0, 0, 0, ST_OK, 0, 0, REUSE_MIN, 0, 0);
    row_typed(MODE_PUT, 2, 0, 0, 0, 0, ST_OK, 0, 1, REUSE_MIN, 0, 1);
    // positive counter, no data
    row_typed(MODE_SET, 3, 0, 0, 0, 1, ST_OK, 0, 0, 1, 0, 0);
    row_typed(MODE_GET, 3, 0, 0, 0, 0, ST_OK, 0, 0, 0, 0, 0);
    row_pred(MODE_SET, 4, 0, 0, 3, 2);
    row_pred(MODE_PUT, 4, 32'hA5A5A5A5, 1, 0, 0);
    row_pred(MODE_DEC, 4, 0, 0, 0, 0);
    row_pred(MODE_QUERY, 4, 0, 0, 0, 0);
    row_typed(MODE_CLEAR, 0, 0, 0, 0, 0, ST_OK, 0, 0, 0, 255, 0);
    row_pred(MODE_GET, 0, 0, 0, 0, 0);
    row_pred(MODE_SET, 0, 0, 0, 0, -1);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      offer_op(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].res);

    for (int mix = 0; mix < 4; mix++) begin
      case (mix)
        0: begin
          snd_idle_pct = 0;
          rcv_stall_pct = 0;
          hold_token++;
        end
        1: begin
          snd_idle_pct = 73;
          rcv_stall_pct = 0;
        end
        2: begin
          snd_idle_pct = 0;
          rcv_stall_pct = 73;
        end
        default: begin
          snd_idle_pct = 11;
          rcv_stall_pct = 11;
        end
      endcase
      repeat (RAND_PER_MIX) offer_op(rand_op(), 1'b0, unused);
    end
    s_tvalid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
